// ===== design/lbs_pkg.sv =====
// ----------------------------------------------------------------------------
// LED blink sequencer package
// Command codes, queue entry type, sequencer states and fixed widths.
// ----------------------------------------------------------------------------
package lbs_pkg;

    localparam int CMD_W    = 2;
    localparam int ID_W     = 3;
    localparam int PERIOD_W = 16;
    localparam int DUTY_W   = 7;
    localparam int REPS_W   = 17;
    localparam int SCAN_W   = 10;
    localparam int LEVEL_W  = 3;

    // period * duty fits in 23 bits, scan * 100 in 17 bits
    localparam int DVD_W    = PERIOD_W + DUTY_W;
    localparam int DVS_W    = 17;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [SCAN_W-1:0] SCAN_RESET = 10'd10;
    localparam logic [DUTY_W-1:0] PCT_FULL   = 7'd100;

    localparam logic [CMD_W-1:0] CMD_TICK      = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FLASH     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FORCE_ON  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_FORCE_OFF = 2'd3;

    typedef enum logic [2:0] {
        OP_TICK,
        OP_FLASH,
        OP_FORCE_ON,
        OP_FORCE_OFF,
        OP_REJECT
    } op_t;

    typedef struct packed {
        op_t                       op;
        logic [ID_W-1:0]           led_id;
        logic [PERIOD_W-1:0]       period_ms;
        logic [DUTY_W-1:0]         duty_pct;
        logic signed [REPS_W-1:0]  repeat_count;
    } cmd_entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT,
        ST_DONE
    } seq_state_t;

endpackage

// ===== design/lbs_if.sv =====
// ----------------------------------------------------------------------------
// LED blink sequencer channel interfaces
// Valid/ready channels for commands, results and the scan period register.
// ----------------------------------------------------------------------------
interface lbs_in_if;
    logic                                valid;
    logic                                ready;
    logic [lbs_pkg::CMD_W-1:0]           cmd;
    logic [lbs_pkg::ID_W-1:0]            led_id;
    logic [lbs_pkg::PERIOD_W-1:0]        period_ms;
    logic [lbs_pkg::DUTY_W-1:0]          duty_pct;
    logic signed [lbs_pkg::REPS_W-1:0]   repeat_count;

    modport source (output valid, cmd, led_id, period_ms, duty_pct, repeat_count,
                    input ready);
    modport sink   (input valid, cmd, led_id, period_ms, duty_pct, repeat_count,
                    output ready);
endinterface

interface lbs_out_if;
    logic                           valid;
    logic                           ready;
    logic [lbs_pkg::LEVEL_W-1:0]    led_levels;
    logic                           status;

    modport source (output valid, led_levels, status, input ready);
    modport sink   (input valid, led_levels, status, output ready);
endinterface

interface lbs_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [lbs_pkg::SCAN_W-1:0]     scan_period_ms;

    modport source (output valid, scan_period_ms, input ready);
    modport sink   (input valid, scan_period_ms, output ready);
endinterface

// ===== design/led_blink_sequencer.sv =====
// ----------------------------------------------------------------------------
// LED blink sequencer
// Per-LED blink engine with flash, force-on and force-off commands.
// ----------------------------------------------------------------------------
// Timing: flash, force and rejected commands go from the queue to the result
//   register by way of the back end's done state; a tick steps each blinking
//   LED in turn through the one divider that the blinking LEDs share.
// Throughput: one command in flight in the back end; the queue takes up to
//   two more while it works or while a result waits at the output.
// Reset: all LEDs dark, blinking stopped, counters clear, scan period 10 ms.
module led_blink_sequencer #(
    parameter int NUM_LEDS = 3
) (
    input  logic       clk,
    input  logic       rst_n,
    lbs_in_if.sink     req,
    lbs_out_if.source  rsp,
    lbs_cfg_if.sink    cfg
);
    import lbs_pkg::*;

    // front to queue
    logic       push;
    cmd_entry_t push_entry;

    // queue to back
    logic       pop;
    cmd_entry_t pop_entry;
    logic       q_full;
    logic       q_empty;

    // Front end: accept a command transaction whenever the queue has room,
    // check id and duty, and tag it with an operation code.
    lbs_front #(
        .NUM_LEDS (NUM_LEDS)
    ) u_front (
        .req     (req),
        .q_full  (q_full),
        .q_push  (push),
        .q_entry (push_entry)
    );

    // Queue: decouple acceptance from execution so either side may stall.
    lbs_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .full       (q_full),
        .empty      (q_empty)
    );

    // Back end: apply settings, step every blinking LED on a tick through the shared
    // divider, and hold the result in the output register until taken.
    lbs_back #(
        .NUM_LEDS (NUM_LEDS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_entry (pop_entry),
        .q_pop   (pop),
        .cfg     (cfg),
        .rsp     (rsp)
    );

endmodule

// ===== design/lbs_front.sv =====
// ----------------------------------------------------------------------------
// LED blink sequencer front end
// Accept command transactions, check parameters and classify them.
// ----------------------------------------------------------------------------
module lbs_front #(
    parameter int NUM_LEDS = 3
) (
    lbs_in_if.sink              req,
    input  logic                q_full,
    output logic                q_push,
    output lbs_pkg::cmd_entry_t q_entry
);
    import lbs_pkg::*;

    logic bad_id;
    logic bad_duty;

    assign req.ready = !q_full;
    assign q_push    = req.valid && !q_full;

    assign bad_id   = 32'(req.led_id) >= NUM_LEDS;
    assign bad_duty = req.duty_pct > PCT_FULL;

    always_comb
    begin
        q_entry.led_id       = req.led_id;
        q_entry.period_ms    = req.period_ms;
        q_entry.duty_pct     = req.duty_pct;
        q_entry.repeat_count = req.repeat_count;
        case (req.cmd)
            CMD_TICK:      q_entry.op = OP_TICK;
            CMD_FLASH:     q_entry.op = (bad_id || bad_duty) ? OP_REJECT : OP_FLASH;
            CMD_FORCE_ON:  q_entry.op = bad_id ? OP_REJECT : OP_FORCE_ON;
            CMD_FORCE_OFF: q_entry.op = bad_id ? OP_REJECT : OP_FORCE_OFF;
            default:       q_entry.op = OP_REJECT;
        endcase
    end

endmodule

// ===== design/lbs_fifo.sv =====
// ----------------------------------------------------------------------------
// LED blink sequencer command queue
// Short queue of classified commands between front end and back end.
// ----------------------------------------------------------------------------
module lbs_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  lbs_pkg::cmd_entry_t push_entry,
    input  logic                pop,
    output lbs_pkg::cmd_entry_t pop_entry,
    output logic                full,
    output logic                empty
);
    import lbs_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_entry_t       mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full      = count_reg == CNT_W'(QUEUE_DEPTH);
    assign empty     = count_reg == '0;
    assign pop_entry = mem_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== design/lbs_div.sv =====
// ----------------------------------------------------------------------------
// LED blink sequencer divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lbs_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [lbs_pkg::DVD_W-1:0]   dividend,
    input  logic [lbs_pkg::DVS_W-1:0]   divisor,
    output logic                        done,
    output logic [lbs_pkg::DVD_W-1:0]   quotient
);
    import lbs_pkg::*;

    localparam int CNT_W = $clog2(DVD_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W-1:0] dvs_reg;

    logic [DVS_W:0]   shifted;
    logic [DVS_W:0]   diff;
    logic             take;

    assign shifted  = {rem_reg, quo_reg[DVD_W-1]};
    assign diff     = shifted - {1'b0, dvs_reg};
    assign take     = shifted >= {1'b0, dvs_reg};
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= take ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
            quo_reg <= {quo_reg[DVD_W-2:0], take};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(DVD_W - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DVD_W - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

endmodule

// ===== design/lbs_back.sv =====
// ----------------------------------------------------------------------------
// LED blink sequencer back end
// Execute queued commands on per-LED blink state and register the result.
// ----------------------------------------------------------------------------
module lbs_back #(
    parameter int NUM_LEDS = 3
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  lbs_pkg::cmd_entry_t q_entry,
    output logic                q_pop,
    lbs_cfg_if.sink             cfg,
    lbs_out_if.source           rsp
);
    import lbs_pkg::*;

    localparam int IDX_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;

    seq_state_t                state_reg, state_next;
    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic                      reject_reg, reject_next;
    logic [SCAN_W-1:0]         scan_reg;

    logic [PERIOD_W-1:0]       period_reg [NUM_LEDS];
    logic [PERIOD_W-1:0]       period_next [NUM_LEDS];
    logic [DUTY_W-1:0]         duty_reg [NUM_LEDS];
    logic [DUTY_W-1:0]         duty_next [NUM_LEDS];
    logic signed [REPS_W-1:0]  left_reg [NUM_LEDS];
    logic signed [REPS_W-1:0]  left_next [NUM_LEDS];
    logic [PERIOD_W-1:0]       on_cnt_reg [NUM_LEDS];
    logic [PERIOD_W-1:0]       on_cnt_next [NUM_LEDS];
    logic [PERIOD_W-1:0]       off_cnt_reg [NUM_LEDS];
    logic [PERIOD_W-1:0]       off_cnt_next [NUM_LEDS];
    logic [NUM_LEDS-1:0]       off_phase_reg, off_phase_next;
    logic [NUM_LEDS-1:0]       lit_reg, lit_next;

    logic                      out_valid_reg;
    logic [LEVEL_W-1:0]        levels_reg;
    logic                      status_reg;
    logic                      out_load;
    logic [LEVEL_W-1:0]        levels;

    logic [SCAN_W-1:0]         scan_eff;
    logic [DVS_W-1:0]          divisor;
    logic [DUTY_W-1:0]         share;
    logic [DVD_W-1:0]          dividend;
    logic                      div_start;
    logic                      div_done;
    logic [DVD_W-1:0]          ticks;
    logic [IDX_W-1:0]          cmd_idx;
    logic                      last_led;

    assign cfg.ready = 1'b1;

    assign scan_eff = (scan_reg == '0) ? SCAN_W'(1) : scan_reg;
    assign divisor  = DVS_W'(scan_eff) * DVS_W'(PCT_FULL);
    assign share    = off_phase_reg[idx_reg] ? (PCT_FULL - duty_reg[idx_reg])
                                             : duty_reg[idx_reg];
    assign dividend = DVD_W'(period_reg[idx_reg]) * DVD_W'(share);
    assign cmd_idx  = IDX_W'(q_entry.led_id);
    assign last_led = idx_reg == IDX_W'(NUM_LEDS - 1);

    lbs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (ticks)
    );

    // only the first LEVEL_W LEDs reach the result
    generate
        for (genvar g = 0; g < LEVEL_W; g++)
        begin : g_level
            if (g < NUM_LEDS)
            begin : g_on
                assign levels[g] = lit_reg[g];
            end
            else
            begin : g_off
                assign levels[g] = 1'b0;
            end
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        reject_next    = reject_reg;
        period_next    = period_reg;
        duty_next      = duty_reg;
        left_next      = left_reg;
        on_cnt_next    = on_cnt_reg;
        off_cnt_next   = off_cnt_reg;
        off_phase_next = off_phase_reg;
        lit_next       = lit_reg;
        q_pop          = 1'b0;
        div_start      = 1'b0;
        out_load       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop       = 1'b1;
                    reject_next = 1'b0;
                    state_next  = ST_DONE;
                    case (q_entry.op)
                        OP_TICK:
                        begin
                            idx_next   = '0;
                            state_next = ST_SCAN;
                        end
                        OP_FLASH:
                        begin
                            period_next[cmd_idx] = q_entry.period_ms;
                            duty_next[cmd_idx]   = q_entry.duty_pct;
                            left_next[cmd_idx]   = q_entry.repeat_count;
                        end
                        OP_FORCE_ON:
                        begin
                            lit_next[cmd_idx]  = 1'b1;
                            left_next[cmd_idx] = '0;
                        end
                        OP_FORCE_OFF:
                        begin
                            lit_next[cmd_idx]  = 1'b0;
                            left_next[cmd_idx] = '0;
                        end
                        default:
                        begin
                            reject_next = 1'b1;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                if (left_reg[idx_reg] == '0)
                begin
                    // stopped LED: drop counters, keep level
                    on_cnt_next[idx_reg]    = '0;
                    off_cnt_next[idx_reg]   = '0;
                    off_phase_next[idx_reg] = 1'b0;
                    idx_next   = idx_reg + 1'b1;
                    state_next = last_led ? ST_DONE : ST_SCAN;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_WAIT;
                end
            end

            ST_WAIT:
            begin
                if (div_done)
                begin
                    if (!off_phase_reg[idx_reg])
                    begin
                        if (DVD_W'(on_cnt_reg[idx_reg]) < ticks)
                        begin
                            on_cnt_next[idx_reg] = on_cnt_reg[idx_reg] + 1'b1;
                            lit_next[idx_reg]    = 1'b1;
                        end
                        else
                        begin
                            off_phase_next[idx_reg] = 1'b1;
                            on_cnt_next[idx_reg]    = '0;
                        end
                    end
                    else
                    begin
                        if (DVD_W'(off_cnt_reg[idx_reg]) < ticks)
                        begin
                            off_cnt_next[idx_reg] = off_cnt_reg[idx_reg] + 1'b1;
                            lit_next[idx_reg]     = 1'b0;
                        end
                        else
                        begin
                            off_phase_next[idx_reg] = 1'b0;
                            off_cnt_next[idx_reg]   = '0;
                            if (left_reg[idx_reg] > 0)
                            begin
                                left_next[idx_reg] = left_reg[idx_reg] - 1'b1;
                            end
                        end
                    end
                    idx_next   = idx_reg + 1'b1;
                    state_next = last_led ? ST_DONE : ST_SCAN;
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            reject_reg    <= 1'b0;
            scan_reg      <= SCAN_RESET;
            off_phase_reg <= '0;
            lit_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_LEDS; i++)
            begin
                period_reg[i]  <= '0;
                duty_reg[i]    <= '0;
                left_reg[i]    <= '0;
                on_cnt_reg[i]  <= '0;
                off_cnt_reg[i] <= '0;
            end
        end
        else
        begin
            idx_reg       <= idx_next;
            reject_reg    <= reject_next;
            off_phase_reg <= off_phase_next;
            lit_reg       <= lit_next;
            period_reg    <= period_next;
            duty_reg      <= duty_next;
            left_reg      <= left_next;
            on_cnt_reg    <= on_cnt_next;
            off_cnt_reg   <= off_cnt_next;
            if (cfg.valid)
            begin
                scan_reg <= cfg.scan_period_ms;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            levels_reg <= levels;
            status_reg <= reject_reg;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.led_levels = levels_reg;
    assign rsp.status     = status_reg;

endmodule
